FILE: rtl/biphasic_stim_pulse_generator_defines.svh
// assertion macros shared by the rtl files
// every property is sampled on clk; the reset form is disabled while rst_n is low
`ifndef BIPHASIC_STIM_PULSE_GENERATOR_DEFINES_SVH
`define BIPHASIC_STIM_PULSE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define BSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BSP_ASSERT(label, prop, msg)
`define BSP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/bsp_pkg.sv
`default_nettype none

package bsp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PULSE_WIDTH_FIRST  = 3'd0,
    REG_PULSE_WIDTH_SECOND = 3'd1,
    REG_GAP_US             = 3'd2,
    REG_PERIOD_US          = 3'd3,
    REG_ON_MS              = 3'd4,
    REG_OFF_MS             = 3'd5
  } cfg_reg_e;

  // start request codes
  localparam logic [1:0] START_NONE   = 2'd0;
  localparam logic [1:0] START_FIRST  = 2'd1;
  localparam logic [1:0] START_SECOND = 2'd2;

  localparam logic [15:0] RST_PULSE_WIDTH = 16'd200;
  localparam logic [15:0] RST_GAP_US      = 16'd50;
  localparam logic [15:0] RST_PERIOD_US   = 16'd20000;
  localparam logic [15:0] RST_ON_MS       = 16'd550;
  localparam logic [15:0] RST_OFF_MS      = 16'd1050;

  localparam logic [15:0] ELAPSED_SAT = 16'hFFFF;

  typedef struct packed {
    logic [15:0] pulse_width_first;
    logic [15:0] pulse_width_second;
    logic [15:0] gap_us;
    logic [15:0] period_us;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0] stim_active;
    logic [1:0] cycle_enable;
    logic [1:0] bridge_enable;
    logic [1:0] overcurrent;
    logic [1:0] start_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0] pos_drive;
    logic [1:0] neg_drive;
    logic       output_gate;
    logic       burst_on;
  } out_item_t;

  // lower limit is checked first; if the limits cross, only values below it get it
  function automatic logic [15:0] clamp_width(
    input logic [15:0] v,
    input logic [15:0] lo,
    input logic [15:0] hi
  );
    logic [15:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bsp_cfg.sv
`default_nettype none

module bsp_cfg
  import bsp_pkg::*;
#(
  parameter int WIDTH_MIN = 50,
  parameter int WIDTH_MAX = 1000
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_regs_t                   regs
);

  localparam logic [15:0] WMIN = 16'(WIDTH_MIN);
  localparam logic [15:0] WMAX = 16'(WIDTH_MAX);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PULSE_WIDTH_FIRST:  regs_nxt.pulse_width_first  = clamp_width(cfg_data, WMIN, WMAX);
        REG_PULSE_WIDTH_SECOND: regs_nxt.pulse_width_second = clamp_width(cfg_data, WMIN, WMAX);
        REG_GAP_US:             regs_nxt.gap_us             = cfg_data;
        REG_PERIOD_US:          regs_nxt.period_us          = cfg_data;
        REG_ON_MS:              regs_nxt.on_ms              = cfg_data;
        REG_OFF_MS:             regs_nxt.off_ms             = cfg_data;
        default:                regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pulse_width_first  <= RST_PULSE_WIDTH;
      regs_r.pulse_width_second <= RST_PULSE_WIDTH;
      regs_r.gap_us             <= RST_GAP_US;
      regs_r.period_us          <= RST_PERIOD_US;
      regs_r.on_ms              <= RST_ON_MS;
      regs_r.off_ms             <= RST_OFF_MS;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bsp_core.sv
`default_nettype none

`include "biphasic_stim_pulse_generator_defines.svh"

module bsp_core
  import bsp_pkg::*;
#(
  parameter int BRIDGES      = 2,
  parameter int TICKS_PER_MS = 1000
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_acc,
  input  in_item_t       in_item,
  input  cfg_regs_t      regs,
  output out_item_t      result
);

  localparam int PRE_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam logic [PRE_W:0] TICKS = (PRE_W + 1)'(TICKS_PER_MS);

  logic [15:0]      phase_r, phase_nxt;
  logic [PRE_W-1:0] pre_r, pre_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic             running_r, running_nxt;
  logic             on_r, on_nxt;
  logic             gate_r, gate_nxt;

  logic [1:0]   stim, cyc, ben, start_mask;
  logic         start_hit;
  logic [PRE_W:0] pre_inc;
  logic [15:0]  el_tick;
  logic         active;
  logic [15:0]  width_b [2];
  logic [16:0]  gap_end [2];
  logic [17:0]  neg_end [2];
  logic [1:0]   en, pos, neg;
  logic [16:0]  phase_inc;

  // start request decode; second bridge exists only if configured
  always_comb begin
    start_hit  = (in_item.start_request == START_FIRST) ||
                 ((in_item.start_request == START_SECOND) && (BRIDGES >= 2));
    start_mask = 2'b00;
    if (start_hit) begin
      start_mask = (in_item.start_request == START_FIRST) ? 2'b01 : 2'b10;
    end
    cyc  = in_item.cycle_enable | start_mask;
    ben  = in_item.bridge_enable | start_mask;
    stim = in_item.stim_active & ~start_mask;
  end

  // burst timer
  always_comb begin
    running_nxt = running_r;
    on_nxt      = on_r;
    gate_nxt    = gate_r;
    pre_nxt     = pre_r;
    elapsed_nxt = elapsed_r;
    pre_inc     = '0;
    el_tick     = '0;
    if (start_hit) begin
      running_nxt = 1'b1;
      on_nxt      = 1'b1;
      gate_nxt    = 1'b1;
      pre_nxt     = '0;
      elapsed_nxt = '0;
    end
    if (running_nxt) begin
      pre_inc = {1'b0, pre_nxt} + 1'b1;
      el_tick = elapsed_nxt;
      if (pre_inc >= TICKS) begin
        pre_nxt = '0;
        if (elapsed_nxt != ELAPSED_SAT) begin
          el_tick = elapsed_nxt + 16'd1;
        end
      end else begin
        pre_nxt = pre_inc[PRE_W-1:0];
      end
      elapsed_nxt = el_tick;
      if (cyc == 2'b00) begin
        running_nxt = 1'b0;
        gate_nxt    = (stim != 2'b00);
      end else if (on_nxt && (el_tick >= regs.on_ms)) begin
        gate_nxt    = (stim != 2'b00);
        on_nxt      = 1'b0;
        elapsed_nxt = '0;
        pre_nxt     = '0;
      end else if (!on_nxt && (el_tick >= regs.off_ms)) begin
        gate_nxt    = 1'b1;
        on_nxt      = 1'b1;
        elapsed_nxt = '0;
        pre_nxt     = '0;
      end
    end
    active = running_nxt && on_nxt;
  end

  // per-bridge leg timing
  always_comb begin
    width_b[0] = regs.pulse_width_first;
    width_b[1] = regs.pulse_width_second;
    for (int b = 0; b < 2; b++) begin
      gap_end[b] = {1'b0, width_b[b]} + {1'b0, regs.gap_us};
      neg_end[b] = {1'b0, gap_end[b]} + {2'b00, width_b[b]};
      en[b]  = (b < BRIDGES) && (stim[b] || (cyc[b] && active)) &&
               ben[b] && !in_item.overcurrent[b];
      pos[b] = 1'b0;
      neg[b] = 1'b0;
      if (en[b]) begin
        if (phase_r < width_b[b]) begin
          pos[b] = 1'b1;
        end else if ({1'b0, phase_r} >= gap_end[b] && {2'b00, phase_r} < neg_end[b]) begin
          neg[b] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    phase_inc = {1'b0, phase_r} + 17'd1;
    if (phase_inc >= {1'b0, regs.period_us}) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_inc[15:0];
    end
  end

  always_comb begin
    result.pos_drive   = pos;
    result.neg_drive   = neg;
    result.output_gate = gate_nxt;
    result.burst_on    = active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      pre_r     <= '0;
      elapsed_r <= '0;
      running_r <= 1'b0;
      on_r      <= 1'b0;
      gate_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      pre_r     <= pre_nxt;
      elapsed_r <= elapsed_nxt;
      running_r <= running_nxt;
      on_r      <= on_nxt;
      gate_r    <= gate_nxt;
    end
  end

  `BSP_ASSERT(a_pre_range, {1'b0, pre_r} < TICKS, "prescaler beyond one millisecond")
  `BSP_ASSERT(a_start_runs, in_acc && start_hit |=> running_r, "start did not run the burst timer")
  `BSP_ASSERT(a_legs_excl, (pos & neg) == 2'b00, "both legs of one bridge driven")
  `BSP_ASSERT(a_on_needs_run, result.burst_on |-> running_nxt, "burst on without running timer")

endmodule

`default_nettype wire

FILE: rtl/bsp_obuf.sv
`default_nettype none

`include "biphasic_stim_pulse_generator_defines.svh"

module bsp_obuf
  import bsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r) begin
      if (push) begin
        main_valid_nxt = 1'b1;
        main_nxt       = push_data;
      end
    end else if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else begin
      if (pop && push) begin
        main_nxt = push_data;
      end else if (pop) begin
        main_valid_nxt = 1'b0;
      end else if (push) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  `BSP_ASSERT(a_skid_order, skid_valid_r |-> main_valid_r, "skid holds data ahead of main")
  `BSP_ASSERT(a_skid_fill, push && !pop && main_valid_r |=> skid_valid_r, "stalled result lost")
  `BSP_ASSERT(a_drain, pop && !push && !skid_valid_r |=> !main_valid_r, "result repeated")

endmodule

`default_nettype wire

FILE: rtl/biphasic_stim_pulse_generator.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_data   (in_item_t, one microsecond tick)
// out      output     out_valid / out_stall out_data (out_item_t, one per tick)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// a tick is taken every clock while in_stall is low; its result is registered in the
// output buffer before out_data shows it; start decode, burst timer and leg compares
// are one combinational pass from the state registers into the output register
// rst_n is synchronous; it clears the timers and restores register defaults
// a two-entry output buffer lets a tick be taken while a result waits; in_stall
// rises only when both entries hold results that out_stall keeps back
`default_nettype none

module biphasic_stim_pulse_generator
  import bsp_pkg::*;
#(
  parameter int BRIDGES      = 2,
  parameter int TICKS_PER_MS = 1000,
  parameter int WIDTH_MIN    = 50,
  parameter int WIDTH_MAX    = 1000
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // tick transactions
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  in_item_t                    in_data,
  // result transactions
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_regs_t regs;
  out_item_t result;
  logic      in_acc;
  logic      buf_full;

  // a tick is taken whenever the output buffer has a free entry
  assign in_stall = buf_full;
  assign in_acc   = in_valid && !in_stall;

  // register file, width writes saturate to the allowed range
  bsp_cfg #(
    .WIDTH_MIN (WIDTH_MIN),
    .WIDTH_MAX (WIDTH_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // phase counter, burst timer and leg drive; state moves only on an accepted tick
  bsp_core #(
    .BRIDGES      (BRIDGES),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_item (in_data),
    .regs    (regs),
    .result  (result)
  );

  // result register plus skid entry
  bsp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/biphasic_stim_pulse_generator_tb.sv
`timescale 1ns / 1ps

module biphasic_stim_pulse_generator_tb
  import bsp_pkg::*;
;

  localparam int BRIDGES      = 2;
  localparam int TICKS_PER_MS = 1000;
  localparam int WIDTH_MIN    = 50;
  localparam int WIDTH_MAX    = 1000;

  // extra drain after the last result, which leaves through the output buffer registers
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 100;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  biphasic_stim_pulse_generator #(
    .BRIDGES      (BRIDGES),
    .TICKS_PER_MS (TICKS_PER_MS),
    .WIDTH_MIN    (WIDTH_MIN),
    .WIDTH_MAX    (WIDTH_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copy kept by the predictor
  logic [15:0] width_first  = RST_PULSE_WIDTH;
  logic [15:0] width_second = RST_PULSE_WIDTH;
  logic [15:0] gap_len      = RST_GAP_US;
  logic [15:0] period_len   = RST_PERIOD_US;
  logic [15:0] on_len_ms    = RST_ON_MS;
  logic [15:0] off_len_ms   = RST_OFF_MS;

  // timer and phase state of the predictor, all zero after reset
  logic [15:0] phase_cnt    = '0;
  logic [9:0]  ms_pre       = '0;
  logic [15:0] ms_elapsed   = '0;
  logic        burst_run    = 1'b0;
  logic        burst_in_on  = 1'b0;
  logic        gate_state   = 1'b0;

  // leg drives predicted for accepted ticks, oldest first
  out_item_t   expected_drive_q[$];

  int          err_cnt      = 0;
  int          sent_cnt     = 0;
  int          cycle_cnt    = 0;
  int          hold_left    = 0;
  bit          in_idle_en   = 1'b0;
  bit          out_idle_en  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hang or a lost result ends here
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // one microsecond tick of the pulse generator, advancing the predictor state
  function automatic out_item_t predict_drive(in_item_t t);
    logic [1:0]  stim;
    logic [1:0]  cyc;
    logic [1:0]  ben;
    logic [1:0]  oc;
    logic [1:0]  req_bit;
    logic        active;
    logic        en;
    int unsigned w;
    int unsigned gap_end;
    int unsigned neg_end;
    int unsigned nxt;
    int          b;
    out_item_t   r;
    stim = t.stim_active;
    cyc  = t.cycle_enable;
    ben  = t.bridge_enable;
    oc   = t.overcurrent;
    r    = '0;
    // a start request forces its bridge on for this tick and restarts the burst in on
    if (t.start_request == START_FIRST || t.start_request == START_SECOND) begin
      req_bit     = (t.start_request == START_FIRST) ? 2'b01 : 2'b10;
      cyc         = cyc | req_bit;
      ben         = ben | req_bit;
      stim        = stim & ~req_bit;
      burst_run   = 1'b1;
      burst_in_on = 1'b1;
      ms_elapsed  = '0;
      ms_pre      = '0;
      gate_state  = 1'b1;
    end
    if (burst_run) begin
      ms_pre = ms_pre + 10'd1;
      if (ms_pre >= TICKS_PER_MS) begin
        ms_pre = '0;
        if (ms_elapsed != ELAPSED_SAT) ms_elapsed = ms_elapsed + 16'd1;
      end
      if (cyc == 2'b00) begin
        burst_run  = 1'b0;
        gate_state = (stim != 2'b00);
      end else if (burst_in_on && ms_elapsed >= on_len_ms) begin
        gate_state  = (stim != 2'b00);
        burst_in_on = 1'b0;
        ms_elapsed  = '0;
        ms_pre      = '0;
      end else if (!burst_in_on && ms_elapsed >= off_len_ms) begin
        gate_state  = 1'b1;
        burst_in_on = 1'b1;
        ms_elapsed  = '0;
        ms_pre      = '0;
      end
    end
    active = burst_run && burst_in_on;
    for (b = 0; b < BRIDGES && b < 2; b++) begin
      en = (stim[b] || (cyc[b] && active)) && ben[b] && !oc[b];
      if (en) begin
        w       = (b == 0) ? width_first : width_second;
        gap_end = w + gap_len;
        neg_end = gap_end + w;
        if (phase_cnt < w) begin
          r.pos_drive[b] = 1'b1;
        end else if (phase_cnt >= gap_end && phase_cnt < neg_end) begin
          r.neg_drive[b] = 1'b1;
        end
      end
    end
    // wraps at the period, and also when a shorter period left the phase beyond it
    nxt = phase_cnt + 1;
    if (nxt >= period_len) phase_cnt = '0;
    else phase_cnt = 16'(nxt);
    r.output_gate = gate_state;
    r.burst_on    = active;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    err_cnt++;
    if (err_cnt <= PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got_v, want_v);
    end
  endtask

  task automatic check_drive(out_item_t got);
    out_item_t want;
    if (expected_drive_q.size() == 0) begin
      report_mismatch("result with no tick pending", int'(got), 0);
    end else begin
      want = expected_drive_q.pop_front();
      if (got.pos_drive !== want.pos_drive)
        report_mismatch("pos_drive", int'(got.pos_drive), int'(want.pos_drive));
      if (got.neg_drive !== want.neg_drive)
        report_mismatch("neg_drive", int'(got.neg_drive), int'(want.neg_drive));
      if (got.output_gate !== want.output_gate)
        report_mismatch("output_gate", int'(got.output_gate), int'(want.output_gate));
      if (got.burst_on !== want.burst_on)
        report_mismatch("burst_on", int'(got.burst_on), int'(want.burst_on));
    end
  endtask

  // result side: check each accepted transaction, then hold off at random while out idle mode is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_drive(out_data);
        hold_left = out_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // send one tick; valid stays high after acceptance so back-to-back ticks
  // never see valid lowered and raised in the same step
  task automatic send_tick(in_item_t t);
    int gap;
    // every 64 ticks pick new idle modes, giving stretches without gaps
    if (sent_cnt % 64 == 0) begin
      in_idle_en  = ($urandom_range(0, 2) != 0);
      out_idle_en = ($urandom_range(0, 2) != 0);
    end
    gap = in_idle_en ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_drive_q.push_back(predict_drive(t));
    sent_cnt++;
  endtask

  // drop valid and let every pending result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    logic [15:0] sat;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // width writes saturate to the limits
    if (val < WIDTH_MIN) sat = 16'(WIDTH_MIN);
    else if (val > WIDTH_MAX) sat = 16'(WIDTH_MAX);
    else sat = val;
    case (idx)
      REG_PULSE_WIDTH_FIRST:  width_first  = sat;
      REG_PULSE_WIDTH_SECOND: width_second = sat;
      REG_GAP_US:             gap_len      = val;
      REG_PERIOD_US:          period_len   = val;
      REG_ON_MS:              on_len_ms    = val;
      REG_OFF_MS:             off_len_ms   = val;
      default: ;
    endcase
  endtask

  // all six registers, only once the block has gone quiet
  task automatic load_regs(logic [15:0] wf, logic [15:0] ws, logic [15:0] gap,
                           logic [15:0] per, logic [15:0] on_ms, logic [15:0] off_ms);
    wait_idle();
    write_reg(REG_PULSE_WIDTH_FIRST, wf);
    write_reg(REG_PULSE_WIDTH_SECOND, ws);
    write_reg(REG_GAP_US, gap);
    write_reg(REG_PERIOD_US, per);
    write_reg(REG_ON_MS, on_ms);
    write_reg(REG_OFF_MS, off_ms);
    cfg_valid <= 1'b0;
  endtask

  // held enables with noise per mille; cycle enable flips far more rarely
  // so the burst timer gets to run; reroll changes the held flags every reroll ticks
  task automatic run_ticks(input int n, inout in_item_t base, input int noise_pm,
                           input int start_pm, input int reroll);
    in_item_t t;
    int       i;
    for (i = 0; i < n; i++) begin
      if (reroll != 0 && i % reroll == reroll - 1) begin
        base.stim_active   = 2'($urandom);
        base.bridge_enable = 2'($urandom);
        base.overcurrent   = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00;
      end
      t = base;
      if ($urandom_range(0, 999) < noise_pm) t.stim_active = 2'($urandom);
      if ($urandom_range(0, 999) < noise_pm) t.bridge_enable = 2'($urandom);
      if ($urandom_range(0, 999) < noise_pm) t.overcurrent = 2'($urandom);
      if ($urandom_range(0, 999) < noise_pm / 8) t.cycle_enable = 2'($urandom);
      if ($urandom_range(0, 999) < start_pm) t.start_request = 2'($urandom_range(1, 3));
      else t.start_request = START_NONE;
      send_tick(t);
    end
  endtask

  // field extremes under the reset register values
  task automatic test_field_extremes();
    send_tick(in_item_t'{2'b00, 2'b00, 2'b00, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b11, 2'b00, 2'b11, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b11, 2'b00, 2'b11, 2'b11, START_NONE});
    send_tick(in_item_t'{2'b11, 2'b00, 2'b00, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b01, 2'b00, 2'b11, 2'b10, START_NONE});
    send_tick(in_item_t'{2'b10, 2'b00, 2'b11, 2'b01, START_NONE});
    // start overrides stim, cycle and bridge enable of its own bridge
    send_tick(in_item_t'{2'b11, 2'b00, 2'b00, 2'b00, START_FIRST});
    send_tick(in_item_t'{2'b00, 2'b11, 2'b11, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b01, 2'b10, 2'b11, 2'b00, START_NONE});
    // cycle enable gone: timer stops, gate follows stim
    send_tick(in_item_t'{2'b10, 2'b00, 2'b11, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b00, 2'b00, 2'b11, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b11, 2'b00, 2'b00, 2'b01, START_SECOND});
    send_tick(in_item_t'{2'b00, 2'b01, 2'b11, 2'b00, START_NONE});
    send_tick(in_item_t'{2'b00, 2'b00, 2'b00, 2'b00, START_NONE});
    // request code three is ignored
    send_tick(in_item_t'{2'b00, 2'b00, 2'b11, 2'b00, 2'b11});
    send_tick(in_item_t'{2'b11, 2'b11, 2'b11, 2'b11, 2'b11});
    send_tick(in_item_t'{2'b11, 2'b11, 2'b11, 2'b00, START_FIRST});
    send_tick(in_item_t'{2'b00, 2'b00, 2'b00, 2'b00, START_NONE});
  endtask

  // register extremes: saturating widths, zero and full periods, zero timers,
  // and a period cut below the current phase
  task automatic test_config_extremes();
    in_item_t base;
    base = in_item_t'{2'b01, 2'b11, 2'b11, 2'b00, START_NONE};
    load_regs(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    run_ticks(20, base, 300, 150, 8);
    load_regs(16'd49, 16'd1001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_ticks(20, base, 300, 150, 8);
    load_regs(16'd50, 16'd1000, 16'd1, 16'd7, 16'd1, 16'd1);
    run_ticks(20, base, 300, 150, 8);
    load_regs(16'd1000, 16'd50, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
    run_ticks(20, base, 300, 150, 8);
  endtask

  // whole positive, gap, negative and rest windows within one short period;
  // the second bridge's negative phase ends right at the period
  task automatic test_pulse_shape();
    in_item_t base;
    base = in_item_t'{2'b11, 2'b00, 2'b11, 2'b00, START_NONE};
    load_regs(16'd50, 16'd60, 16'd10, 16'd130, RST_ON_MS, RST_OFF_MS);
    run_ticks(130, base, 20, 0, 65);
  endtask

  // burst on and off phases, with zero timers first and then real milliseconds
  task automatic test_burst_cycle();
    in_item_t base;
    base = in_item_t'{2'b00, 2'b11, 2'b11, 2'b00, START_NONE};
    load_regs(16'd60, 16'd90, 16'd20, 16'd250, 16'd0, 16'd0);
    send_tick(in_item_t'{2'b00, 2'b00, 2'b00, 2'b00, START_FIRST});
    run_ticks(40, base, 40, 20, 20);
    base.cycle_enable = 2'b00;
    run_ticks(10, base, 40, 0, 10);
    // one millisecond on, then off for a single tick before on again;
    // cycle enable is held steady so the timer keeps running
    load_regs(16'd50, 16'd50, 16'd0, 16'd200, 16'd1, 16'd0);
    base.cycle_enable = 2'b11;
    send_tick(in_item_t'{2'b00, 2'b00, 2'b00, 2'b00, START_SECOND});
    run_ticks(1020, base, 7, 0, 200);
  endtask

  // random register settings with noisy ticks and frequent start requests
  task automatic test_random_mix();
    in_item_t base;
    int       r;
    base = in_item_t'{2'b01, 2'b01, 2'b11, 2'b00, START_NONE};
    for (r = 0; r < 3; r++) begin
      load_regs(16'($urandom_range(0, 1100)), 16'($urandom_range(0, 1100)),
                16'($urandom_range(0, 120)),
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)),
                16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)));
      base.cycle_enable = 2'($urandom);
      run_ticks(25, base, 100, 20, 30);
    end
  endtask

  initial begin
    // synchronous reset held low for a while, then released
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_config_extremes();
    test_pulse_shape();
    test_burst_cycle();
    test_random_mix();
    wait_idle();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
